FILE: rtl/s256_pkg.sv
// Shared definitions for the SHA-256 stream hasher: round constants, initial
// hash values, the sequencer state type, the control bundle and the sigma functions.
// Depends on nothing; the message schedule, the round unit and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package s256_pkg;

   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned LenPos      = 56;
   localparam int unsigned Rounds      = 64;
   localparam int unsigned DigestWords = 8;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUT
   } s256_state_type;

   // Control bundle from the sequencer to the schedule and round units.
   typedef struct packed {
      logic       shift_byte;
      logic [7:0] byte_val;
      logic       sched_step;
      logic       load_vars;
      logic       round_en;
      logic [5:0] round_idx;
      logic       chain_add;
      logic       chain_init;
      logic [2:0] rd_idx;
   } s256_ctrl_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/s256_req_if.sv
// Input channel of the SHA-256 stream hasher: valid/ready plus a mode bit and one message byte.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface s256_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/s256_rsp_if.sv
// Result channel of the SHA-256 stream hasher: valid/ready plus one digest word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface s256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;

   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/s256_msg_sched.sv
// Message buffer and schedule window: a 512-bit shift line filled a byte at a time,
// then stepped a 32-bit word at a time to produce W[t]. Depends on s256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s256_msg_sched
   import s256_pkg::*;
(
   input  logic          clock,
   input  s256_ctrl_type ctrl,
   output logic [31:0]   w_cur
);

   logic [511:0] msg_ff;
   logic [511:0] msg_in;
   logic [31:0]  w_new;

   // Word i of the window sits at msg_ff[511-32*i -: 32]; word 0 is W[t].
   always_comb begin
      w_new = small_sigma1(msg_ff[63:32]) + msg_ff[223:192]
            + small_sigma0(msg_ff[479:448]) + msg_ff[511:480];
      msg_in = msg_ff;
      if (ctrl.shift_byte) begin
         msg_in = {msg_ff[503:0], ctrl.byte_val};
      end else if (ctrl.sched_step) begin
         msg_in = {msg_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
   end

   assign w_cur = msg_ff[511:480];

endmodule

`default_nettype wire

FILE: rtl/s256_round.sv
// Shared compression round unit: working variables a..h, one round per cycle,
// and the chaining words with their feed-forward add. Depends on s256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s256_round
   import s256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  s256_ctrl_type ctrl,
   input  logic [31:0]   w_cur,
   output logic [31:0]   digest_word
);

   logic [31:0] v_ff     [DigestWords];
   logic [31:0] v_in     [DigestWords];
   logic [31:0] chain_ff [DigestWords];
   logic [31:0] chain_in [DigestWords];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] choose;
   logic [31:0] major;

   always_comb begin
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1     = v_ff[7] + big_sigma1(v_ff[4]) + choose + ROUND_K[ctrl.round_idx] + w_cur;
      t2     = big_sigma0(v_ff[0]) + major;

      v_in = v_ff;
      if (ctrl.load_vars) begin
         v_in = chain_ff;
      end else if (ctrl.round_en) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end

      chain_in = chain_ff;
      if (ctrl.chain_init) begin
         chain_in = INIT_H;
      end else if (ctrl.chain_add) begin
         for (int i = 0; i < DigestWords; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_H;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign digest_word = chain_ff[ctrl.rd_idx];

endmodule

`default_nettype wire

FILE: rtl/sha256_stream_hasher.sv
// An absorbed word leaves the block idle unless it completes a 64-byte block; that word
// keeps the block busy through its accept, 64 rounds and the chaining add.
// A finalize word takes its accept and the padding bytes, added one at a time (up to 64 for
// one block, up to 72 over two blocks), then rounds and chaining add per block (one or two);
// the 8 digest words then appear, one per cycle while the sink is ready.
// The shared round unit performs the rounds of every block, one round per cycle.
// Reset (synchronous, active high) restores the initial hash values and clears the counts.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher
   import s256_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   s256_req_if.sink        req_ch,
   s256_rsp_if.source      rsp_ch
);

   // Sequencer state and counters.
   s256_state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;          // bytes held in the current block
   logic [60:0] byte_cnt_ff, byte_cnt_in;  // message length in bytes, wraps with the bit length
   logic [5:0]  round_ff, round_in;
   logic [2:0]  word_ff, word_in;
   logic        pad_placed_ff, pad_placed_in;  // the 0x80 marker has gone in
   logic        len_blk_ff, len_blk_in;        // the block being padded carries the length
   logic        final_ff, final_in;            // the block in compression is the last one
   logic        pad_active_ff, pad_active_in;  // a finalize is in progress

   s256_ctrl_type ctrl;
   logic [31:0]   w_cur;
   logic [63:0]   bit_len;
   logic [7:0]    len_byte;
   logic [7:0]    gen_byte;
   logic          req_fire;
   logic          rsp_fire;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // The length field occupies block bytes 56..63, most significant byte first,
   // so the low three bits of the fill count pick the byte of the bit length.
   assign bit_len  = {byte_cnt_ff, 3'b000};
   assign len_byte = bit_len[{~fill_ff[2:0], 3'b000} +: 8];

   // Padding byte stream: the marker, then zeros, then the length where it belongs.
   always_comb begin
      if (!pad_placed_ff) begin
         gen_byte = PAD_BYTE;
      end else if (len_blk_ff && (fill_ff >= 6'(LenPos))) begin
         gen_byte = len_byte;
      end else begin
         gen_byte = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         byte_cnt_ff   <= '0;
         round_ff      <= '0;
         word_ff       <= '0;
         pad_placed_ff <= 1'b0;
         len_blk_ff    <= 1'b0;
         final_ff      <= 1'b0;
         pad_active_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         byte_cnt_ff   <= byte_cnt_in;
         round_ff      <= round_in;
         word_ff       <= word_in;
         pad_placed_ff <= pad_placed_in;
         len_blk_ff    <= len_blk_in;
         final_ff      <= final_in;
         pad_active_ff <= pad_active_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      byte_cnt_in   = byte_cnt_ff;
      round_in      = round_ff;
      word_in       = word_ff;
      pad_placed_in = pad_placed_ff;
      len_blk_in    = len_blk_ff;
      final_in      = final_ff;
      pad_active_in = pad_active_ff;

      ctrl           = '0;
      ctrl.round_idx = round_ff;
      ctrl.rd_idx    = word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_ch.mode) begin
                  // Absorb: the byte enters the block; a full block starts the rounds.
                  ctrl.shift_byte = 1'b1;
                  ctrl.byte_val   = req_ch.data_byte;
                  fill_in         = fill_ff + 6'd1;
                  byte_cnt_in     = byte_cnt_ff + 61'd1;
                  if (fill_ff == 6'(BlockBytes - 1)) begin
                     ctrl.load_vars = 1'b1;
                     round_in       = '0;
                     final_in       = 1'b0;
                     state_in       = ST_ROUND;
                  end
               end else begin
                  // Finalize: the length fits in this block only if the marker
                  // lands before the length field.
                  pad_placed_in = 1'b0;
                  len_blk_in    = (fill_ff < 6'(LenPos));
                  pad_active_in = 1'b1;
                  state_in      = ST_PAD;
               end
            end
         end

         ST_PAD: begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = gen_byte;
            pad_placed_in   = 1'b1;
            fill_in         = fill_ff + 6'd1;
            if (fill_ff == 6'(BlockBytes - 1)) begin
               ctrl.load_vars = 1'b1;
               round_in       = '0;
               final_in       = len_blk_ff;
               state_in       = ST_ROUND;
            end
         end

         ST_ROUND: begin
            ctrl.round_en   = 1'b1;
            ctrl.sched_step = 1'b1;
            round_in        = round_ff + 6'd1;
            if (round_ff == 6'(Rounds - 1)) begin
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            ctrl.chain_add = 1'b1;
            if (final_ff) begin
               word_in  = '0;
               state_in = ST_OUT;
            end else if (pad_active_ff) begin
               // The marker spilled past the length field: one more block of
               // zeros ends in the length.
               len_blk_in = 1'b1;
               state_in   = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_OUT: begin
            if (rsp_fire) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'(DigestWords - 1)) begin
                  // Digest delivered: start the next message from scratch.
                  ctrl.chain_init = 1'b1;
                  fill_in         = '0;
                  byte_cnt_in     = '0;
                  pad_active_in   = 1'b0;
                  final_in        = 1'b0;
                  state_in        = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   s256_msg_sched u_sched (
      .clock (clock),
      .ctrl  (ctrl),
      .w_cur (w_cur)
   );

   s256_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .w_cur       (w_cur),
      .digest_word (rsp_ch.digest_word)
   );

   // The block takes a word only when idle and shows results only in the output state,
   // both straight from registered state.
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = (state_ff == ST_OUT);
   assign rsp_ch.word_index = word_ff;
   assign rsp_ch.last       = (word_ff == 3'(DigestWords - 1));

   // A word that completes a block must start the rounds at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_ch.mode && (fill_ff == 6'(BlockBytes - 1)))
         |=> (state_ff == ST_ROUND) && (round_ff == 6'd0))
      else $error("full block did not start compression");

   // The last round always hands over to the chaining add.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'(Rounds - 1)) |=> (state_ff == ST_UPDATE))
      else $error("round sequence did not end in the chaining add");

   // After the last digest word the block is empty and ready for a new message.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last)
         |=> req_ch.ready && (fill_ff == 6'd0) && (byte_cnt_ff == 61'd0))
      else $error("state not cleared after digest");

   // Digest words only leave when the padded length has gone through compression.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff == ST_UPDATE) && (fill_ff == 6'd0))
      else $error("digest shown before the final block was compressed");

endmodule

`default_nettype wire

FILE: sim/sha256_stream_hasher_tb.sv
// Self-checking testbench for sha256_stream_hasher: drives message bytes and finalize
// words, predicts each digest with its own SHA-256 model and checks every result word.
// Depends on rtl/s256_req_if.sv, rtl/s256_rsp_if.sv and rtl/sha256_stream_hasher.sv.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

   // Mode codes carried by the input word.
   localparam logic MODE_ABSORB   = 1'b0;
   localparam logic MODE_FINALIZE = 1'b1;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam int unsigned BLOCK_SIZE = 64;
   localparam int unsigned LEN_FIELD  = 56;

   // Cycles with no word moving on either channel before the run is declared hung.
   // The slowest legal gap is a two-block finalize plus a stall.
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   // Quiet time after the last digest, long enough for a stray two-block finalize.
   localparam int unsigned TAIL_CYCLES = 250;
   // Random-traffic word count on top of the boundary messages.
   localparam int unsigned RANDOM_TRAFFIC_WORDS = 12;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // One digest word as the result channel should present it.
   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } digest_beat_type;

   // Ways the result side applies back-pressure.
   typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_PERIODIC} sink_pattern_type;

   logic clock;
   logic reset;

   s256_req_if word_in ();
   s256_rsp_if digest_out ();

   sha256_stream_hasher uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (word_in),
      .rsp_ch (digest_out)
   );

   // Predictor state: the chaining words, the partly filled block, and the length.
   logic [31:0]  hash_state [8];
   logic [7:0]   msg_block [64];
   int unsigned  block_fill;
   logic [63:0]  msg_bits;

   digest_beat_type expected_digest_words [$];

   int unsigned  mismatches;
   int unsigned  messages_hashed;
   int unsigned  bytes_absorbed;
   int unsigned  words_checked;
   int unsigned  words_sent;
   int unsigned  idle_cycles;

   sink_pattern_type sink_pattern;
   int unsigned      stall_phase;
   bit               sender_bursty;
   int unsigned      burst_left;

   // ------------------------------------------------------------------------
   // Clock and reset. Reset is asserted from the start and then released
   // at a falling edge, once, for the whole run.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // SHA-256 predictor.
   // ------------------------------------------------------------------------
   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Returns the predictor to the start of a new message.
   function automatic void restart_digest();
      for (int i = 0; i < 8; i++) begin
         hash_state[i] = IV_WORDS[i];
      end
      block_fill = 0;
      msg_bits   = '0;
   endfunction

   function automatic void stage_byte(input logic [7:0] b);
      msg_block[block_fill] = b;
      block_fill++;
   endfunction

   // Runs the 64 rounds over the staged block and folds the result into the chain.
   function automatic void sha256_compress();
      logic [31:0] w [64];
      logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      va = hash_state[0]; vb = hash_state[1]; vc = hash_state[2]; vd = hash_state[3];
      ve = hash_state[4]; vf = hash_state[5]; vg = hash_state[6]; vh = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg))
              + ROUND_CONST[i] + w[i];
         t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
         vh = vg; vg = vf; vf = ve; ve = vd + t1;
         vd = vc; vc = vb; vb = va; va = t1 + t2;
      end
      hash_state[0] += va; hash_state[1] += vb; hash_state[2] += vc; hash_state[3] += vd;
      hash_state[4] += ve; hash_state[5] += vf; hash_state[6] += vg; hash_state[7] += vh;
   endfunction

   // Applies one accepted input word. A finalize pads the message, compresses the
   // last one or two blocks and queues the eight digest words it should produce.
   function automatic void sha256_absorb_word(input logic mode, input logic [7:0] data);
      digest_beat_type beat;
      if (mode == MODE_ABSORB) begin
         stage_byte(data);
         msg_bits += 64'd8;
         bytes_absorbed++;
         if (block_fill == BLOCK_SIZE) begin
            sha256_compress();
            block_fill = 0;
         end
      end else begin
         stage_byte(PAD_MARK);
         // No room left for the length field: this block is closed with zeros and
         // the length goes into one more block.
         if (block_fill > LEN_FIELD) begin
            while (block_fill < BLOCK_SIZE) begin
               stage_byte(8'h00);
            end
            sha256_compress();
            block_fill = 0;
         end
         while (block_fill < LEN_FIELD) begin
            stage_byte(8'h00);
         end
         for (int i = 7; i >= 0; i--) begin
            stage_byte(msg_bits[8*i +: 8]);
         end
         sha256_compress();
         for (int i = 0; i < 8; i++) begin
            beat.digest_word = hash_state[i];
            beat.word_index  = 3'(i);
            beat.last        = (i == 7);
            expected_digest_words.push_back(beat);
         end
         messages_hashed++;
         restart_digest();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result side: back-pressure driver and checker.
   // The ready pattern is chosen by each test, in the random traffic per message; it changes only at falling edges.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      case (sink_pattern)
         SINK_ALWAYS: begin
            digest_out.ready <= 1'b1;
         end
         SINK_RANDOM: begin
            digest_out.ready <= ($urandom_range(0, 2) != 0);
         end
         default: begin
            // Ready is high while stall_phase is below 4; stall_phase wraps after 6.
            digest_out.ready <= (stall_phase < 4);
         end
      endcase
      stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
   end

   // Every accepted digest word is matched against the oldest expectation.
   // Sampling happens at the rising edge, before any flop of the block updates.
   always @(posedge clock) begin
      digest_beat_type want;
      if (!reset && digest_out.valid && digest_out.ready) begin
         if (expected_digest_words.size() == 0) begin
            $error("digest word %h (index %0d) arrived with nothing pending",
                   digest_out.digest_word, digest_out.word_index);
            mismatches++;
         end else begin
            want = expected_digest_words.pop_front();
            words_checked++;
            if (digest_out.digest_word !== want.digest_word) begin
               $error("digest_word: expected %h, got %h", want.digest_word,
                      digest_out.digest_word);
               mismatches++;
            end
            if (digest_out.word_index !== want.word_index) begin
               $error("word_index: expected %0d, got %0d", want.word_index,
                      digest_out.word_index);
               mismatches++;
            end
            if (digest_out.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, digest_out.last);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: counts cycles in which no word moves on either channel. A long
   // count means a lost digest or a block that stopped taking input.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (word_in.valid && word_in.ready)
          || (digest_out.valid && digest_out.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("Watchdog expired: no word moved for %0d cycles, %0d digest words pending",
               WATCHDOG_LIMIT, expected_digest_words.size());
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Input side.
   // ------------------------------------------------------------------------

   // Sends one word, called at a falling edge and returning at one. In bursty mode
   // the sender drops valid for a random pause between bursts of random length.
   // The predictor sees the word at the edge where it is accepted.
   task automatic send_word(input logic mode, input logic [7:0] data);
      if (sender_bursty && burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         word_in.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      word_in.valid     <= 1'b1;
      word_in.mode      <= mode;
      word_in.data_byte <= data;
      do begin
         @(posedge clock);
      end while (!word_in.ready);
      sha256_absorb_word(mode, data);
      words_sent++;
      @(negedge clock);
   endtask

   // A message of random bytes followed by a finalize with a random (ignored) byte.
   task automatic send_random_message(input int unsigned len);
      for (int unsigned n = 0; n < len; n++) begin
         send_word(MODE_ABSORB, 8'($urandom_range(0, 255)));
      end
      send_word(MODE_FINALIZE, 8'($urandom_range(0, 255)));
   endtask

   // The sender goes quiet until every pending digest word has been taken.
   // The loop waits for a falling edge before it checks, so that valid never drops and rises in one step.
   task automatic hold_until_digests_drained();
      word_in.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (expected_digest_words.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Two empty messages in a row; the second finalize carries a nonzero byte,
   // which the block has to ignore.
   task automatic test_empty_message();
      sink_pattern  = SINK_ALWAYS;
      sender_bursty = 1'b0;
      send_word(MODE_FINALIZE, 8'h00);
      send_word(MODE_FINALIZE, 8'hff);
   endtask

   // The classic three-byte message, then the byte extremes and the pad value
   // itself as message data, with stalls on both sides.
   task automatic test_short_messages();
      send_word(MODE_ABSORB, 8'h61);
      send_word(MODE_ABSORB, 8'h62);
      send_word(MODE_ABSORB, 8'h63);
      send_word(MODE_FINALIZE, 8'h5a);
      sink_pattern  = SINK_RANDOM;
      sender_bursty = 1'b1;
      send_word(MODE_ABSORB, 8'h00);
      send_word(MODE_ABSORB, 8'hff);
      send_word(MODE_ABSORB, PAD_MARK);
      send_word(MODE_FINALIZE, 8'h00);
   endtask

   // Lengths around the padding limits: 55 bytes still fit the length field into
   // one block, 56 bytes force a second padding block, 64 bytes fill a block
   // exactly and leave padding to a block of its own.
   task automatic test_block_boundaries();
      sink_pattern  = SINK_ALWAYS;
      sender_bursty = 1'b0;
      send_random_message(55);
      sink_pattern  = SINK_PERIODIC;
      sender_bursty = 1'b1;
      send_random_message(56);
      sink_pattern  = SINK_RANDOM;
      send_random_message(64);
   endtask

   // Random-length messages with random idling. Mostly short well-formed messages,
   // some close to a block boundary, and some bare finalize words.
   task automatic test_random_traffic();
      int unsigned start_words;
      int unsigned msg_len;
      int unsigned msg_num;
      start_words = words_sent;
      msg_num     = 0;
      while (words_sent - start_words < RANDOM_TRAFFIC_WORDS) begin
         case ($urandom_range(0, 9))
            0: msg_len = 0;
            1: msg_len = $urandom_range(57, 63);
            default: msg_len = $urandom_range(1, 12);
         endcase
         sink_pattern  = sink_pattern_type'($urandom_range(0, 2));
         sender_bursty = ($urandom_range(0, 3) != 0);
         send_random_message(msg_len);
         msg_num++;
         if (msg_num == 1) begin
            hold_until_digests_drained();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      word_in.valid      = 1'b0;
      word_in.mode       = MODE_ABSORB;
      word_in.data_byte  = 8'h00;
      digest_out.ready   = 1'b0;
      sink_pattern       = SINK_ALWAYS;
      stall_phase        = 0;
      sender_bursty      = 1'b0;
      burst_left         = 0;
      mismatches         = 0;
      messages_hashed    = 0;
      bytes_absorbed     = 0;
      words_checked      = 0;
      words_sent         = 0;
      restart_digest();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_message();
      test_short_messages();
      test_block_boundaries();
      test_random_traffic();

      // Everything is sent: wait for the remaining digests, then give the block
      // time to show any word it should not produce.
      word_in.valid <= 1'b0;
      while (expected_digest_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Hashed %0d messages (%0d bytes) and checked %0d digest words,",
               messages_hashed, bytes_absorbed, words_checked);
      $display("covering empty, short, block-boundary and random lengths under stalls.");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
